// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: sv/vlns_pkg.sv
// ----------------------------------------------------------------------------
// Voltmeter LCD nibble sequencer package
// Shared types, display constants and the init command table.
// ----------------------------------------------------------------------------
package vlns_pkg;

  localparam int HundW = 9;

  // Item kinds on the request channel.
  localparam logic CMD_INIT   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // LCD register select codes.
  localparam logic RS_COMMAND = 1'b0;
  localparam logic RS_DATA    = 1'b1;

  localparam logic [16:0] SCALE_MUL = 17'd125;

  localparam logic [7:0] LINE1_BASE = 8'h80;
  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] ASCII_DOT  = 8'h2E;
  localparam logic [7:0] CLEAR_CMD  = 8'h01;

  localparam logic [10:0] WAIT_CMD_HI  = 11'd100;
  localparam logic [10:0] WAIT_CMD_LO  = 11'd40;
  localparam logic [10:0] WAIT_CLEAR   = 11'd2040;
  localparam logic [10:0] WAIT_DATA_HI = 11'd0;
  localparam logic [10:0] WAIT_DATA_LO = 11'd100;

  localparam logic [3:0] INIT_LAST_STEP   = 4'd11;
  localparam logic [3:0] SAMPLE_LAST_STEP = 4'd15;

  typedef struct packed {
    logic             cmd;
    logic [HundW-1:0] hund;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } back_status_t;

  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h33;
      3'd1:    b = 8'h32;
      3'd2:    b = 8'h28;
      3'd3:    b = 8'h0E;
      3'd4:    b = 8'h01;
      3'd5:    b = 8'h06;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: sv/vlns_front.sv
// ----------------------------------------------------------------------------
// Voltmeter LCD front end
// Accepts requests, scales samples to hundredths of a volt and queues jobs.
// ----------------------------------------------------------------------------
module vlns_front (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  cmd,
  input  logic [9:0]            sample,
  input  vlns_pkg::queue_status_t qstat,
  output logic                  push,
  output vlns_pkg::job_t        job
);

  logic [16:0] product;

  // code * 125 / 256 gives hundredths of a volt, floor rounded.
  assign product  = {7'd0, sample} * vlns_pkg::SCALE_MUL;
  assign in_stall = qstat.full;
  assign push     = in_valid && !qstat.full;

  always_comb begin
    job.cmd  = cmd;
    job.hund = (cmd == vlns_pkg::CMD_SAMPLE) ? product[16:8] : '0;
  end

endmodule

// File: sv/vlns_queue.sv
// ----------------------------------------------------------------------------
// Voltmeter LCD job queue
// Two-entry FIFO between the front end and the nibble sequencer.
// ----------------------------------------------------------------------------
module vlns_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  vlns_pkg::job_t          wr_job,
  input  logic                    pop,
  output vlns_pkg::job_t          rd_job,
  output vlns_pkg::queue_status_t qstat
);

  vlns_pkg::job_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  assign rd_job      = entries[rd_ptr];
  assign qstat.full  = (count == 2'd2);
  assign qstat.empty = (count == 2'd0);

endmodule

// File: sv/vlns_back.sv
// ----------------------------------------------------------------------------
// Voltmeter LCD nibble sequencer back end
// Splits a job into LCD bytes and sends them as registered nibble transfers.
// ----------------------------------------------------------------------------
module vlns_back (
  input  logic                    clk,
  input  logic                    rst,
  input  vlns_pkg::job_t          head,
  input  vlns_pkg::queue_status_t qstat,
  output vlns_pkg::back_status_t  bstat,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    reg_select,
  output logic [3:0]              nibble,
  output logic [10:0]             wait_us,
  output logic                    last
);

  logic       busy;
  logic [3:0] step;
  logic       is_sample;
  logic [3:0] ones;
  logic [3:0] tens;
  logic [3:0] units;

  logic [3:0] ones_next;
  logic [3:0] tens_next;
  logic [3:0] units_next;
  logic [8:0] rem100;
  logic [6:0] rem10;

  logic       advance;
  logic       at_end;
  logic       pop;
  logic [2:0] pair;
  logic       hi;
  logic [7:0] cur_byte;
  logic       cur_rs;
  logic [3:0] cur_nib;
  logic [10:0] cur_wait;

  // Digit split by compare chains; the remainders stay below 100 and 10.
  always_comb begin
    ones_next = 4'd0;
    for (int k = 1; k < 5; k++) begin
      if (head.hund >= 9'(k * 100)) begin
        ones_next = 4'(k);
      end
    end
    rem100 = head.hund - 9'({5'd0, ones_next} * 9'd100);
    rem10  = rem100[6:0];
    tens_next = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (rem10 >= 7'(k * 10)) begin
        tens_next = 4'(k);
      end
    end
    units_next = 4'(rem10 - 7'({3'd0, tens_next} * 7'd10));
  end

  always_comb begin
    pair = step[3:1];
    hi   = !step[0];
    if (!is_sample) begin
      cur_rs   = vlns_pkg::RS_COMMAND;
      cur_byte = vlns_pkg::init_byte(pair);
    end else if (!pair[0]) begin
      // Cursor command for column pair[2:1] of line 1.
      cur_rs   = vlns_pkg::RS_COMMAND;
      cur_byte = vlns_pkg::LINE1_BASE + {6'd0, pair[2:1]};
    end else begin
      cur_rs = vlns_pkg::RS_DATA;
      unique case (pair[2:1])
        2'd0:    cur_byte = vlns_pkg::ASCII_ZERO + {4'd0, ones};
        2'd1:    cur_byte = vlns_pkg::ASCII_DOT;
        2'd2:    cur_byte = vlns_pkg::ASCII_ZERO + {4'd0, tens};
        default: cur_byte = vlns_pkg::ASCII_ZERO + {4'd0, units};
      endcase
    end
    cur_nib = hi ? cur_byte[7:4] : cur_byte[3:0];
    if (cur_rs == vlns_pkg::RS_COMMAND) begin
      if (hi) begin
        cur_wait = vlns_pkg::WAIT_CMD_HI;
      end else if (cur_byte == vlns_pkg::CLEAR_CMD) begin
        cur_wait = vlns_pkg::WAIT_CLEAR;
      end else begin
        cur_wait = vlns_pkg::WAIT_CMD_LO;
      end
    end else begin
      cur_wait = hi ? vlns_pkg::WAIT_DATA_HI : vlns_pkg::WAIT_DATA_LO;
    end
    at_end = busy && (step == (is_sample ? vlns_pkg::SAMPLE_LAST_STEP
                                         : vlns_pkg::INIT_LAST_STEP));
  end

  assign advance = !out_valid || !out_stall;
  // The next job loads in the same cycle as the final nibble of this one.
  assign pop     = !qstat.empty && (!busy || (advance && at_end));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= busy;
      end
      if (pop) begin
        busy <= 1'b1;
        step <= 4'd0;
      end else if (busy && advance) begin
        if (at_end) begin
          busy <= 1'b0;
        end
        step <= step + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      is_sample <= head.cmd;
      ones      <= ones_next;
      tens      <= tens_next;
      units     <= units_next;
    end
    if (busy && advance) begin
      reg_select <= cur_rs;
      nibble     <= cur_nib;
      wait_us    <= cur_wait;
      last       <= at_end;
    end
  end

  assign bstat.busy = busy;
  assign bstat.pop  = pop;

endmodule

// File: sv/voltmeter_lcd_nibble_sequencer.sv
// ----------------------------------------------------------------------------
// Voltmeter LCD nibble sequencer
// Turns init requests and converter samples into 4-bit LCD nibble transfers.
// ----------------------------------------------------------------------------
// Path: request, job queue, back end job registers, output registers. Throughput:
// one nibble per cycle unless out_stall holds it; init is 12 nibbles, a sample 16,
// set by the single nibble sequencer. A two-entry job queue keeps requests flowing.
// Reset (synchronous, active high) empties the queue and drops out_valid.
`include "assert_macros.svh"

module voltmeter_lcd_nibble_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [9:0]  sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        reg_select,
  output logic [3:0]  nibble,
  output logic [10:0] wait_us,
  output logic        last
);

  vlns_pkg::queue_status_t qstat;
  vlns_pkg::back_status_t  bstat;
  vlns_pkg::job_t          wr_job;
  vlns_pkg::job_t          head;
  logic                    push;

  vlns_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sample   (sample),
    .qstat    (qstat),
    .push     (push),
    .job      (wr_job)
  );

  vlns_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (bstat.pop),
    .rd_job (head),
    .qstat  (qstat)
  );

  vlns_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .qstat      (qstat),
    .bstat      (bstat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .reg_select (reg_select),
    .nibble     (nibble),
    .wait_us    (wait_us),
    .last       (last)
  );

  `ASSERT_IMP(a_no_push_full, clk, rst, push, !qstat.full)
  `ASSERT_IMP(a_no_pop_empty, clk, rst, bstat.pop, !qstat.empty)
  `ASSERT_NXT(a_idle_quiet, clk, rst, qstat.empty && !bstat.busy && !out_valid, !out_valid)
  `ASSERT_NXT(a_pop_starts, clk, rst, bstat.pop, bstat.busy)

endmodule
